[sv/tcp_pkg.sv]
// package with shared constants, types and helpers of the traced contour perimeter block
`timescale 1ns / 1ps

package tcp_pkg;

  // parameter defaults
  localparam int COORD_BITS_DEF = 12;
  localparam int MAX_POINTS_DEF = 65536;
  localparam int FRAC_BITS_DEF  = 16;

  // fixed widths of sums, gaps and result fields
  localparam int SUM_W       = 29;
  localparam int TOTAL_W     = SUM_W + 1;
  localparam int GAP_W       = 16;
  localparam int COUNT_OUT_W = 17;
  localparam int PERIM_W     = 47;
  localparam int SMALL_W     = 4;
  localparam int K_W         = 32;

  localparam logic [SUM_W-1:0] SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_INIT = SUM_W'(2);

  // (2 - sqrt 2) at 32 fraction bits
  localparam logic [K_W-1:0] CORNER_K32 = 32'd2515933592;

  // fixed totals and corner multipliers of contours with one to four points
  localparam logic [SMALL_W-1:0] SMALL_TOTAL_1   = 4'd4;
  localparam logic [SMALL_W-1:0] SMALL_TOTAL_2   = 4'd6;
  localparam logic [SMALL_W-1:0] SMALL_TOTAL_3   = 4'd8;
  localparam logic [SMALL_W-1:0] SMALL_TOTAL_4   = 4'd8;
  localparam logic [SMALL_W-1:0] SMALL_CORNERS_1 = 4'd2;
  localparam logic [SMALL_W-1:0] SMALL_CORNERS_2 = 4'd3;
  localparam logic [SMALL_W-1:0] SMALL_CORNERS_3 = 4'd3;
  localparam logic [SMALL_W-1:0] SMALL_CORNERS_4 = 4'd4;

  // per-contour closing record passed from the tracer to the perimeter stage
  typedef struct packed {
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
    logic [GAP_W-1:0]   gap_x;
    logic [GAP_W-1:0]   gap_y;
    logic               is_small;
    logic [SMALL_W-1:0] small_total;
  } close_t;

  // saturating add of a step into an axis sum
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [SUM_W-1:0] d);
    logic [SUM_W:0] t;
    t = {1'b0, s} + {1'b0, d};
    return (t > {1'b0, SUM_MAX}) ? SUM_MAX : t[SUM_W-1:0];
  endfunction

endpackage

[sv/tcp_point_if.sv]
// channel interface carrying contour points
`timescale 1ns / 1ps

interface tcp_point_if import tcp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] x_coord;
  logic [COORD_BITS-1:0] y_coord;
  logic                  last_point;

  modport source (output valid, output x_coord, output y_coord, output last_point,
                  input ready);
  modport sink   (input valid, input x_coord, input y_coord, input last_point,
                  output ready);
endinterface

[sv/tcp_result_if.sv]
// channel interface carrying perimeter results
`timescale 1ns / 1ps

interface tcp_result_if import tcp_pkg::*;;
  logic                          valid;
  logic                          ready;
  logic signed [PERIM_W-1:0]     perimeter_q16;
  logic        [COUNT_OUT_W-1:0] corner_total;
  logic        [COUNT_OUT_W-1:0] points_seen;
  logic                          too_many_points;

  modport source (output valid, output perimeter_q16, output corner_total,
                  output points_seen, output too_many_points, input ready);
  modport sink   (input valid, input perimeter_q16, input corner_total,
                  input points_seen, input too_many_points, output ready);
endinterface

[sv/traced_contour_perimeter_core.sv]
// Traced contour perimeter with corner correction, top level.
// Throughput: one point per cycle, except that a point marked last waits until the
// closing record register is free; the state update sits between the point register
// and the closing record register, then one product stage and one rounding stage.
// Reset: asynchronous active low; clears all valid flags and returns contour state
// to its start values (sums at 2, counts and flags at zero).
`timescale 1ns / 1ps

module traced_contour_perimeter_core import tcp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcp_point_if.sink    pt_i,
  tcp_result_if.source res_o
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic             close_valid, close_ready;
  close_t           close_rec;
  logic [CNT_W-1:0] corners, points;
  logic             overflow;

  // contour tracing state
  tcp_trace #(
    .COORD_BITS (COORD_BITS),
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      (CNT_W)
  ) u_trace (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pt_i          (pt_i),
    .close_valid_o (close_valid),
    .close_ready_i (close_ready),
    .close_o       (close_rec),
    .corners_o     (corners),
    .points_o      (points),
    .overflow_o    (overflow)
  );

  // perimeter arithmetic and result register
  tcp_perim #(
    .FRAC_BITS (FRAC_BITS),
    .CNT_W     (CNT_W)
  ) u_perim (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .close_valid_i (close_valid),
    .close_ready_o (close_ready),
    .close_i       (close_rec),
    .corners_i     (corners),
    .points_i      (points),
    .overflow_i    (overflow),
    .res_o         (res_o)
  );

endmodule

[sv/tcp_trace.sv]
// point input register, contour state update and closing record register
`timescale 1ns / 1ps

module tcp_trace import tcp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tcp_point_if.sink        pt_i,
  output logic             close_valid_o,
  input  logic             close_ready_i,
  output close_t           close_o,
  output logic [CNT_W-1:0] corners_o,
  output logic [CNT_W-1:0] points_o,
  output logic             overflow_o
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  // input register
  logic                  a_valid_q;
  logic [COORD_BITS-1:0] a_x_q, a_y_q;
  logic                  a_last_q;
  logic                  a_go, a_ready, b_ready;

  // contour state
  logic [COORD_BITS-1:0] start_x_q, start_y_q, prev_x_q, prev_y_q;
  logic [COORD_BITS-1:0] start_x_d, start_y_d, prev_x_d, prev_y_d;
  logic                  corner_flag_q, corner_flag_d;
  logic [CNT_W-1:0]      corner_count_q, corner_count_d;
  logic [SUM_W-1:0]      sum_x_q, sum_y_q, sum_x_d, sum_y_d;
  logic [CNT_W-1:0]      point_count_q, point_count_d;
  logic                  overflow_q, overflow_d;

  // state after folding in the current point
  logic [COORD_BITS-1:0] start_x_u, start_y_u, prev_x_u, prev_y_u;
  logic                  corner_flag_u;
  logic [CNT_W-1:0]      corner_count_u;
  logic [SUM_W-1:0]      sum_x_u, sum_y_u;
  logic [CNT_W-1:0]      point_count_u;
  logic                  overflow_u;

  logic [COORD_BITS-1:0] dx, dy, gap_x, gap_y;
  logic [COORD_BITS:0]   step_len;

  // closing record register
  logic             b_valid_q;
  close_t           close_q, close_d;
  logic [CNT_W-1:0] corners_q, corners_d;
  logic [CNT_W-1:0] points_q;
  logic             overflow_b_q;

  assign b_ready    = !b_valid_q || close_ready_i;
  assign a_go       = a_valid_q && (!a_last_q || b_ready);
  assign a_ready    = !a_valid_q || a_go;
  assign pt_i.ready = a_ready;

  // point input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (pt_i.valid && a_ready) begin
      a_valid_q <= 1'b1;
    end else if (a_go) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_i.valid && a_ready) begin
      a_x_q    <= pt_i.x_coord;
      a_y_q    <= pt_i.y_coord;
      a_last_q <= pt_i.last_point;
    end
  end

  // edge steps from the previous point
  always_comb begin
    dx       = (a_x_q > prev_x_q) ? (a_x_q - prev_x_q) : (prev_x_q - a_x_q);
    dy       = (a_y_q > prev_y_q) ? (a_y_q - prev_y_q) : (prev_y_q - a_y_q);
    step_len = {1'b0, dx} + {1'b0, dy};
  end

  // fold the point into the contour state
  always_comb begin
    start_x_u      = start_x_q;
    start_y_u      = start_y_q;
    prev_x_u       = prev_x_q;
    prev_y_u       = prev_y_q;
    corner_flag_u  = corner_flag_q;
    corner_count_u = corner_count_q;
    sum_x_u        = sum_x_q;
    sum_y_u        = sum_y_q;
    point_count_u  = point_count_q;
    overflow_u     = overflow_q;
    if (point_count_q < MAX_CNT) begin
      if (point_count_q == '0) begin
        start_x_u      = a_x_q;
        start_y_u      = a_y_q;
        corner_flag_u  = 1'b1;
        corner_count_u = CNT_W'(1);
      end else begin
        sum_x_u = sat_add(sum_x_q, {{(SUM_W-COORD_BITS){1'b0}}, dx});
        sum_y_u = sat_add(sum_y_q, {{(SUM_W-COORD_BITS){1'b0}}, dy});
        if ((step_len > (COORD_BITS+1)'(1)) || !corner_flag_q) begin
          corner_flag_u  = 1'b1;
          corner_count_u = corner_count_q + CNT_W'(1);
        end else begin
          corner_flag_u = 1'b0;
        end
      end
      prev_x_u      = a_x_q;
      prev_y_u      = a_y_q;
      point_count_u = point_count_q + CNT_W'(1);
    end else begin
      overflow_u = 1'b1;
    end
  end

  // next state: a closed contour returns everything to reset values
  always_comb begin
    start_x_d      = start_x_q;
    start_y_d      = start_y_q;
    prev_x_d       = prev_x_q;
    prev_y_d       = prev_y_q;
    corner_flag_d  = corner_flag_q;
    corner_count_d = corner_count_q;
    sum_x_d        = sum_x_q;
    sum_y_d        = sum_y_q;
    point_count_d  = point_count_q;
    overflow_d     = overflow_q;
    if (a_go) begin
      if (a_last_q) begin
        start_x_d      = '0;
        start_y_d      = '0;
        prev_x_d       = '0;
        prev_y_d       = '0;
        corner_flag_d  = 1'b0;
        corner_count_d = '0;
        sum_x_d        = SUM_INIT;
        sum_y_d        = SUM_INIT;
        point_count_d  = '0;
        overflow_d     = 1'b0;
      end else begin
        start_x_d      = start_x_u;
        start_y_d      = start_y_u;
        prev_x_d       = prev_x_u;
        prev_y_d       = prev_y_u;
        corner_flag_d  = corner_flag_u;
        corner_count_d = corner_count_u;
        sum_x_d        = sum_x_u;
        sum_y_d        = sum_y_u;
        point_count_d  = point_count_u;
        overflow_d     = overflow_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q      <= '0;
      start_y_q      <= '0;
      prev_x_q       <= '0;
      prev_y_q       <= '0;
      corner_flag_q  <= 1'b0;
      corner_count_q <= '0;
      sum_x_q        <= SUM_INIT;
      sum_y_q        <= SUM_INIT;
      point_count_q  <= '0;
      overflow_q     <= 1'b0;
    end else begin
      start_x_q      <= start_x_d;
      start_y_q      <= start_y_d;
      prev_x_q       <= prev_x_d;
      prev_y_q       <= prev_y_d;
      corner_flag_q  <= corner_flag_d;
      corner_count_q <= corner_count_d;
      sum_x_q        <= sum_x_d;
      sum_y_q        <= sum_y_d;
      point_count_q  <= point_count_d;
      overflow_q     <= overflow_d;
    end
  end

  // closing edge and fixed small-contour selection
  always_comb begin
    gap_x = (start_x_u > prev_x_u) ? (start_x_u - prev_x_u) : (prev_x_u - start_x_u);
    gap_y = (start_y_u > prev_y_u) ? (start_y_u - prev_y_u) : (prev_y_u - start_y_u);
    close_d.sum_x       = sum_x_u;
    close_d.sum_y       = sum_y_u;
    close_d.gap_x       = {{(GAP_W-COORD_BITS){1'b0}}, gap_x};
    close_d.gap_y       = {{(GAP_W-COORD_BITS){1'b0}}, gap_y};
    close_d.is_small    = 1'b1;
    close_d.small_total = SMALL_TOTAL_1;
    corners_d           = corner_count_u;
    unique case (point_count_u)
      CNT_W'(1): begin
        close_d.small_total = SMALL_TOTAL_1;
        corners_d           = {{(CNT_W-SMALL_W){1'b0}}, SMALL_CORNERS_1};
      end
      CNT_W'(2): begin
        close_d.small_total = SMALL_TOTAL_2;
        corners_d           = {{(CNT_W-SMALL_W){1'b0}}, SMALL_CORNERS_2};
      end
      CNT_W'(3): begin
        close_d.small_total = SMALL_TOTAL_3;
        corners_d           = {{(CNT_W-SMALL_W){1'b0}}, SMALL_CORNERS_3};
      end
      CNT_W'(4): begin
        close_d.small_total = SMALL_TOTAL_4;
        corners_d           = {{(CNT_W-SMALL_W){1'b0}}, SMALL_CORNERS_4};
      end
      default: begin
        close_d.is_small = 1'b0;
      end
    endcase
  end

  // closing record register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_go && a_last_q) begin
      b_valid_q <= 1'b1;
    end else if (close_ready_i) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go && a_last_q) begin
      close_q      <= close_d;
      corners_q    <= corners_d;
      points_q     <= point_count_u;
      overflow_b_q <= overflow_u;
    end
  end

  assign close_valid_o = b_valid_q;
  assign close_o       = close_q;
  assign corners_o     = corners_q;
  assign points_o      = points_q;
  assign overflow_o    = overflow_b_q;

endmodule

[sv/tcp_perim.sv]
// corner correction product, fixed-point rounding and result register
`timescale 1ns / 1ps

module tcp_perim import tcp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int CNT_W     = $clog2(MAX_POINTS_DEF + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             close_valid_i,
  output logic             close_ready_o,
  input  close_t           close_i,
  input  logic [CNT_W-1:0] corners_i,
  input  logic [CNT_W-1:0] points_i,
  input  logic             overflow_i,
  tcp_result_if.source     res_o
);

  localparam int SH     = K_W - FRAC_BITS;
  localparam int PROD_W = CNT_W + K_W;
  localparam int ACC_W  = TOTAL_W + K_W + 2;
  localparam int WIDE_W = CNT_W + COUNT_OUT_W;

  // product stage registers
  logic                c_valid_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [PROD_W-1:0]   prod_q;
  logic [CNT_W-1:0]    corners_q, points_q;
  logic                overflow_q;

  logic                c_ready, d_ready;
  logic [TOTAL_W-1:0]  total_d;
  logic [PROD_W-1:0]   prod_d;
  logic [SUM_W-1:0]    close_x, close_y;

  logic signed [ACC_W-1:0] acc, shifted;
  logic [WIDE_W-1:0]       corners_wide, points_wide;

  assign d_ready       = !res_o.valid || res_o.ready;
  assign c_ready       = !c_valid_q || d_ready;
  assign close_ready_o = c_ready;

  // closing edge sums and corner product
  always_comb begin
    close_x = sat_add(close_i.sum_x, {{(SUM_W-GAP_W){1'b0}}, close_i.gap_x});
    close_y = sat_add(close_i.sum_y, {{(SUM_W-GAP_W){1'b0}}, close_i.gap_y});
    if (close_i.is_small) begin
      total_d = {{(TOTAL_W-SMALL_W){1'b0}}, close_i.small_total};
    end else begin
      total_d = {1'b0, close_x} + {1'b0, close_y};
    end
    prod_d = PROD_W'(corners_i) * PROD_W'(CORNER_K32);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_ready) begin
      c_valid_q <= close_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_ready && close_valid_i) begin
      total_q    <= total_d;
      prod_q     <= prod_d;
      corners_q  <= corners_i;
      points_q   <= points_i;
      overflow_q <= overflow_i;
    end
  end

  // subtract correction at 32 fraction bits, round half up to the output scale
  always_comb begin
    acc = $signed({2'b00, total_q, {K_W{1'b0}}})
        - $signed({{(ACC_W-PROD_W){1'b0}}, prod_q})
        + $signed(ACC_W'(1) << (SH - 1));
    shifted      = acc >>> SH;
    corners_wide = {{COUNT_OUT_W{1'b0}}, corners_q};
    points_wide  = {{COUNT_OUT_W{1'b0}}, points_q};
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_o.valid <= 1'b0;
    end else if (d_ready) begin
      res_o.valid <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_ready && c_valid_q) begin
      res_o.perimeter_q16   <= shifted[PERIM_W-1:0];
      res_o.corner_total    <= corners_wide[COUNT_OUT_W-1:0];
      res_o.points_seen     <= points_wide[COUNT_OUT_W-1:0];
      res_o.too_many_points <= overflow_q;
    end
  end

endmodule
